@@ rtl/gcd_pkg.sv @@
package gcd_pkg;

  // datapath width for CORDIC and Q30 products (Q2.30 plus guard bits)
  localparam int CW = 34;

  localparam int SQRT_STEPS = 31;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [30:0] RAD_PER_UNIT = 31'(PI_Q60 / 64'd1800000000);

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
  localparam logic signed [33:0] LON_HALF = 34'sd1800000000;
  localparam logic signed [33:0] LON_SPAN = 34'sd3600000000;

  localparam logic [29:0] RADIUS_CM = 30'd637100000;
  localparam logic [30:0] DIST_MAX = 31'd2001508680;

  localparam logic [0:0] REG_REF_LAT = 1'd0;
  localparam logic [0:0] REG_REF_LON = 1'd1;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
    32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
    32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128,
    32'd64, 32'd32, 32'd16, 32'd8,
    32'd4, 32'd2, 32'd1, 32'd0
  };

endpackage

@@ rtl/gcd_point_if.sv @@
interface gcd_point_if;
  logic valid;
  logic ready;
  logic signed [30:0] point_latitude;
  logic signed [31:0] point_longitude;

  modport source (output valid, output point_latitude, output point_longitude, input ready);
  modport sink (input valid, input point_latitude, input point_longitude, output ready);
endinterface

@@ rtl/gcd_dist_if.sv @@
interface gcd_dist_if;
  logic valid;
  logic ready;
  logic [30:0] distance_cm;

  modport source (output valid, output distance_cm, input ready);
  modport sink (input valid, input distance_cm, output ready);
endinterface

@@ rtl/gcd_cordic.sv @@
module gcd_cordic #(
  parameter int STAGES = 24,
  parameter bit VECTORING = 1'b0
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [gcd_pkg::CW-1:0] x_i,
  input  logic signed [gcd_pkg::CW-1:0] y_i,
  input  logic signed [gcd_pkg::CW-1:0] z_i,
  output logic signed [gcd_pkg::CW-1:0] x_o,
  output logic signed [gcd_pkg::CW-1:0] y_o,
  output logic signed [gcd_pkg::CW-1:0] z_o
);

  logic signed [gcd_pkg::CW-1:0] x_q [STAGES];
  logic signed [gcd_pkg::CW-1:0] y_q [STAGES];
  logic signed [gcd_pkg::CW-1:0] z_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [gcd_pkg::CW-1:0] x_in, y_in, z_in, dx, dy, ang;
    logic dir;

    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign dx  = y_in >>> i;
    assign dy  = x_in >>> i;
    assign ang = (gcd_pkg::CW)'(gcd_pkg::ATAN_Q30[i]);
    // vectoring with y < 0 takes the same arm as rotation with z >= 0
    assign dir = VECTORING ? y_in[gcd_pkg::CW-1] : ~z_in[gcd_pkg::CW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= dir ? x_in - dx : x_in + dx;
        y_q[i] <= dir ? y_in + dy : y_in - dy;
        z_q[i] <= dir ? z_in - ang : z_in + ang;
      end
    end
  end

  assign x_o = x_q[STAGES-1];
  assign y_o = y_q[STAGES-1];
  assign z_o = z_q[STAGES-1];

endmodule

@@ rtl/gcd_sqrt.sv @@
module gcd_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] a_i,
  output logic [30:0] root_o
);

  localparam int N = gcd_pkg::SQRT_STEPS;

  logic [61:0] n_q [N];
  logic [61:0] r_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [61:0] n_in, r_in, trial;
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);

    if (i == 0) begin : g_first
      assign n_in = {1'b0, a_i, 30'd0};
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= trial) begin
          n_q[i] <= n_in - trial;
          r_q[i] <= (r_in >> 1) + BIT;
        end else begin
          n_q[i] <= n_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[N-1][30:0];

endmodule

@@ rtl/great_circle_distance.sv @@
// Haversine distance from a reference point to each incoming point.
// Channels: point (sink) takes point_latitude / point_longitude in signed
// units of 1e-7 degree; result (source) returns distance_cm, rounded to the
// nearest cm and saturated at half the circumference.
// The reference point is set by cfg_we_i / cfg_index_i / cfg_data_i:
// index 0 is latitude, index 1 longitude; write only while idle.
// Throughput: one transaction per cycle while the receiver takes results. Every
// stage is a register; the four sine/cosine CORDICs and then the arctangent
// CORDIC run CORDIC_STAGES stages each, and the two square roots run
// 31 digit stages in parallel.
// The whole pipeline advances on one enable: when the receiver holds ready
// low with a result waiting, every stage holds; the input stays ready while
// the output register is empty or being taken.
// Reset clears the valid bits and sets the reference point to 0, 0.
module great_circle_distance #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  gcd_point_if.sink   point,
  gcd_dist_if.source  result
);

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + gcd_pkg::SQRT_STEPS + 11;
  localparam int CW  = gcd_pkg::CW;

  logic signed [30:0] ref_lat_q;
  logic signed [31:0] ref_lon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q <= '0;
      ref_lon_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gcd_pkg::REG_REF_LAT: ref_lat_q <= cfg_data_i[30:0];
        gcd_pkg::REG_REF_LON: ref_lon_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld_q;

  assign en          = result.ready | ~vld_q[LAT-1];
  assign point.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], point.valid};
    end
  end

  function automatic logic signed [30:0] clamp_lat(logic signed [30:0] v);
    if (v > gcd_pkg::LAT_LIMIT) return gcd_pkg::LAT_LIMIT;
    if (v < -gcd_pkg::LAT_LIMIT) return -gcd_pkg::LAT_LIMIT;
    return v;
  endfunction

  // S0: capture
  logic signed [30:0] lat_in_q;
  logic signed [31:0] lon_in_q;

  // S1: clamp, differences, longitude wrap
  logic signed [30:0] lat1_c, lat2_c;
  logic signed [33:0] dlon_w, dlon_d;
  logic signed [31:0] src_q [4];

  // S2/S3/S4: magnitude, scale to radians, round
  logic [30:0] mag_q [4];
  logic        sgn2_q [4];
  logic        sgn3_q [4];
  logic [61:0] rad_q [4];
  logic signed [CW-1:0] ang_q [4];

  always_comb begin
    lat1_c = clamp_lat(ref_lat_q);
    lat2_c = clamp_lat(lat_in_q);
    dlon_w = 34'(lon_in_q) - 34'(ref_lon_q);
    if (dlon_w >= gcd_pkg::LON_HALF) begin
      dlon_d = dlon_w - gcd_pkg::LON_SPAN;
    end else if (dlon_w < -gcd_pkg::LON_HALF) begin
      dlon_d = dlon_w + gcd_pkg::LON_SPAN;
    end else begin
      dlon_d = dlon_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_in_q <= point.point_latitude;
      lon_in_q <= point.point_longitude;
      src_q[0] <= 32'(lat1_c);
      src_q[1] <= 32'(lat2_c);
      src_q[2] <= 32'(lat2_c) - 32'(lat1_c);
      src_q[3] <= dlon_d[31:0];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_rad
    // latitudes are full angles, the differences are halved
    localparam int SH = (k < 2) ? 30 : 31;
    logic signed [31:0] v;
    logic [61:0] rnd;
    assign v   = src_q[k];
    assign rnd = (rad_q[k] + (62'(1) << (SH - 1))) >> SH;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sgn2_q[k] <= v[31];
        mag_q[k]  <= v[31] ? 31'(-v) : v[30:0];
        sgn3_q[k] <= sgn2_q[k];
        rad_q[k]  <= 62'(mag_q[k]) * 62'(gcd_pkg::RAD_PER_UNIT);
        ang_q[k]  <= sgn3_q[k] ? -CW'(rnd[31:0]) : CW'(rnd[31:0]);
      end
    end
  end

  logic signed [CW-1:0] cos_v [4];
  logic signed [CW-1:0] sin_v [4];
  logic signed [CW-1:0] zr_v [4];

  for (genvar k = 0; k < 4; k++) begin : g_sc
    gcd_cordic #(.STAGES(N), .VECTORING(1'b0)) u_sincos (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (gcd_pkg::GAIN_Q30),
      .y_i   ('0),
      .z_i   (ang_q[k]),
      .x_o   (cos_v[k]),
      .y_o   (sin_v[k]),
      .z_o   (zr_v[k])
    );
  end

  // S5..S8: Q30 products and the clamped haversine term
  logic signed [2*CW-1:0] p5_q [3];
  logic signed [CW-1:0]   m6_q [3];
  logic signed [2*CW-1:0] pt_q;
  logic signed [CW-1:0]   m3_q;
  logic signed [2*CW-1:0] t_full;
  logic signed [CW:0]     a_sum;
  logic [30:0] a_q, b_q;
  localparam logic signed [2*CW-1:0] HALF_Q30 = (2*CW)'(1) <<< 29;

  always_comb begin
    t_full = (pt_q + HALF_Q30) >>> 30;
    a_sum  = (CW+1)'($signed(t_full[CW-1:0])) + (CW+1)'(m3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q[0] <= (2*CW)'(cos_v[0]) * (2*CW)'(cos_v[1]);
      p5_q[1] <= (2*CW)'(sin_v[3]) * (2*CW)'(sin_v[3]);
      p5_q[2] <= (2*CW)'(sin_v[2]) * (2*CW)'(sin_v[2]);
      for (int j = 0; j < 3; j++) begin
        m6_q[j] <= CW'((p5_q[j] + HALF_Q30) >>> 30);
      end
      pt_q <= (2*CW)'(m6_q[0]) * (2*CW)'(m6_q[1]);
      m3_q <= m6_q[2];
      if (a_sum[CW]) begin
        a_q <= '0;
        b_q <= gcd_pkg::ONE_Q30;
      end else if (a_sum > (CW+1)'(gcd_pkg::ONE_Q30)) begin
        a_q <= gcd_pkg::ONE_Q30;
        b_q <= '0;
      end else begin
        a_q <= a_sum[30:0];
        b_q <= gcd_pkg::ONE_Q30 - a_sum[30:0];
      end
    end
  end

  logic [30:0] ra, rb;

  gcd_sqrt u_sqrt_a (.clk_i(clk_i), .en_i(en), .a_i(a_q), .root_o(ra));
  gcd_sqrt u_sqrt_b (.clk_i(clk_i), .en_i(en), .a_i(b_q), .root_o(rb));

  logic signed [CW-1:0] at_x, at_y, at_z;

  gcd_cordic #(.STAGES(N), .VECTORING(1'b1)) u_atan (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (CW'(rb)),
    .y_i   (CW'(ra)),
    .z_i   ('0),
    .x_o   (at_x),
    .y_o   (at_y),
    .z_o   (at_z)
  );

  // S9/S10: scale by radius, round, saturate
  logic [60:0] p9_q;
  logic [32:0] d_rnd;
  logic [30:0] dist_q;

  assign d_rnd = 33'((p9_q + (61'(1) << 28)) >> 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p9_q   <= at_z[CW-1] ? '0 : 61'(at_z[30:0]) * 61'(gcd_pkg::RADIUS_CM);
      dist_q <= (d_rnd > 33'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : d_rnd[30:0];
    end
  end

  assign result.valid       = vld_q[LAT-1];
  assign result.distance_cm = dist_q;

`ifndef SYNTHESIS
  a_dist_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> result.distance_cm <= gcd_pkg::DIST_MAX)
    else $error("distance above saturation limit");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point.valid && point.ready) |=> vld_q[0])
    else $error("accepted transaction lost at pipeline entry");

  a_hav_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N+8] |-> (a_q <= gcd_pkg::ONE_Q30 && 32'(a_q) + 32'(b_q) == 32'(gcd_pkg::ONE_Q30)))
    else $error("haversine term out of range");
`endif

endmodule
